### rtl/llp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead peak limiter package
// Shared constants, register indexes, types and a helper function.
// ----------------------------------------------------------------------------
package llp_pkg;

   localparam int NUM_CH = 4;
   localparam int CH_W = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 31;
   localparam int DIV_STEPS = 31;
   localparam int STEP_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKAHEAD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NARROW    = 3'd4;

   localparam logic [2:0]  RST_CHANNELS  = 3'd2;
   localparam logic [9:0]  RST_LOOKAHEAD = 10'd240;
   localparam logic [30:0] RST_RELEASE   = 31'd447392;
   localparam logic [30:0] RST_LIMIT     = 31'd2040109465;

   localparam logic [30:0] UNITY_Q30  = 31'h4000_0000;
   localparam logic [30:0] GAIN_FLOOR = 31'd10737418;

   typedef logic signed [31:0] sample_type;
   typedef sample_type [NUM_CH-1:0] frame_type;

   typedef struct packed {
      logic            load;
      logic            clear_step;
      logic            mem_write;
      logic            mem_read;
      logic            peak_step;
      logic            div_start_t;
      logic            div_start_n;
      logic            div_step;
      logic            need_update;
      logic            gain_update;
      logic            release_step;
      logic            dpk_step;
      logic            chk_mul;
      logic            chk_apply;
      logic            out_mul;
      logic            out_store;
      logic            emit;
      logic [CH_W-1:0] chan;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic over_limit;
      logic slope_neg;
      logic chan_last;
      logic out_free;
   } status_type;

   function automatic logic [30:0] mag(input sample_type s);
      logic [31:0] a;
      a = s[31] ? 32'(-s) : 32'(s);
      if (a[31]) begin
         return 31'h7FFF_FFFF;
      end
      return a[30:0];
   endfunction

endpackage

### rtl/llp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead peak limiter channel interfaces
// Valid/ready channels for input frames and limited output frames.
// ----------------------------------------------------------------------------
interface llp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_a;
   logic signed [31:0] sample_b;
   logic signed [31:0] sample_c;
   logic signed [31:0] sample_d;
   logic               end_of_block;

   modport source(output valid, sample_a, sample_b, sample_c, sample_d, end_of_block,
                  input ready);
   modport sink(input valid, sample_a, sample_b, sample_c, sample_d, end_of_block,
                output ready);
endinterface

interface llp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_a;
   logic signed [31:0] out_b;
   logic signed [31:0] out_c;
   logic signed [31:0] out_d;
   logic               block_end;

   modport source(output valid, out_a, out_b, out_c, out_d, block_end, input ready);
   modport sink(input valid, out_a, out_b, out_c, out_d, block_end, output ready);
endinterface

### rtl/lookahead_peak_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead peak limiter
// Delays multichannel frames and scales them by a limiting gain.
// ----------------------------------------------------------------------------
// One input item is one frame of up to four channel samples; each accepted
// item yields exactly one result item carrying the frame that entered
// lookahead_len - 1 items earlier, scaled by the current gain and clamped
// to the limit. Configuration is written through the csr_ port while
// idle: the user must keep to this; the block itself does not enforce it.
// When an item's peak exceeds the limit, two 31-step serial divisions
// (target gain, then attack slope) are run; one shared multiplier is used
// once per channel and once more for the release check while the gain is
// still falling.
// One item is processed at a time; req_chan.ready is high only while the
// block waits for a new item.
// After reset the delay memories are cleared one frame slot per cycle,
// all LOOKAHEAD_MAX slots, before the first item is accepted.
// A finished result waits in an output register; if the receiver stalls,
// the block still accepts and processes the next item and then holds it
// until the output register is free.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter
   import llp_pkg::*;
#(
   parameter int LOOKAHEAD_MAX = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   llp_req_if.sink               req_chan,
   llp_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;
   frame_type  req_frame;
   frame_type  rsp_frame;
   logic       ready;

   assign req_frame[0] = req_chan.sample_a;
   assign req_frame[1] = req_chan.sample_b;
   assign req_frame[2] = req_chan.sample_c;
   assign req_frame[3] = req_chan.sample_d;
   assign req_chan.ready = ready;

   assign rsp_chan.out_a = rsp_frame[0];
   assign rsp_chan.out_b = rsp_frame[1];
   assign rsp_chan.out_c = rsp_frame[2];
   assign rsp_chan.out_d = rsp_frame[3];

   llp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   llp_datapath #(
      .LOOKAHEAD_MAX(LOOKAHEAD_MAX)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_frame   (req_frame),
      .req_eob     (req_chan.end_of_block),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_frame   (rsp_frame),
      .rsp_eob     (rsp_chan.block_end),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

### rtl/llp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead peak limiter controller
// Sequences clearing, storing, division, gain update and output per item.
// ----------------------------------------------------------------------------
module llp_ctrl
   import llp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_WRITE  = 5'd2;
   localparam logic [4:0] S_READ   = 5'd3;
   localparam logic [4:0] S_PEAK   = 5'd4;
   localparam logic [4:0] S_TEST   = 5'd5;
   localparam logic [4:0] S_DIVT   = 5'd6;
   localparam logic [4:0] S_NSTART = 5'd7;
   localparam logic [4:0] S_DIVN   = 5'd8;
   localparam logic [4:0] S_NEED   = 5'd9;
   localparam logic [4:0] S_GAIN   = 5'd10;
   localparam logic [4:0] S_REL    = 5'd11;
   localparam logic [4:0] S_DPK    = 5'd12;
   localparam logic [4:0] S_CMUL   = 5'd13;
   localparam logic [4:0] S_CHK    = 5'd14;
   localparam logic [4:0] S_OMUL   = 5'd15;
   localparam logic [4:0] S_OSTO   = 5'd16;
   localparam logic [4:0] S_EMIT   = 5'd17;

   logic [4:0]        state_ff, state_in;
   logic [CH_W-1:0]   chan_ff, chan_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              step_last;

   assign req_ready = (state_ff == S_IDLE);
   assign step_last = (step_ff == STEP_W'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.chan = chan_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            chan_in = '0;
            state_in = S_PEAK;
         end
         S_PEAK: begin
            cmd.peak_step = 1'b1;
            chan_in = chan_ff + 1'b1;
            if (status.chan_last) begin
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            step_in = '0;
            if (status.over_limit) begin
               cmd.div_start_t = 1'b1;
               state_in = S_DIVT;
            end else begin
               state_in = S_GAIN;
            end
         end
         S_DIVT: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_last) begin
               state_in = S_NSTART;
            end
         end
         S_NSTART: begin
            cmd.div_start_n = 1'b1;
            step_in = '0;
            state_in = S_DIVN;
         end
         S_DIVN: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_last) begin
               state_in = S_NEED;
            end
         end
         S_NEED: begin
            cmd.need_update = 1'b1;
            state_in = S_GAIN;
         end
         S_GAIN: begin
            cmd.gain_update = 1'b1;
            chan_in = '0;
            state_in = status.slope_neg ? S_DPK : S_REL;
         end
         S_REL: begin
            cmd.release_step = 1'b1;
            chan_in = '0;
            state_in = S_OMUL;
         end
         S_DPK: begin
            cmd.dpk_step = 1'b1;
            chan_in = chan_ff + 1'b1;
            if (status.chan_last) begin
               state_in = S_CMUL;
            end
         end
         S_CMUL: begin
            cmd.chk_mul = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            cmd.chk_apply = 1'b1;
            chan_in = '0;
            state_in = S_OMUL;
         end
         S_OMUL: begin
            cmd.out_mul = 1'b1;
            state_in = S_OSTO;
         end
         S_OSTO: begin
            cmd.out_store = 1'b1;
            chan_in = chan_ff + 1'b1;
            state_in = (chan_ff == CH_W'(NUM_CH - 1)) ? S_EMIT : S_OMUL;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         chan_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         step_ff  <= step_in;
      end
   end

endmodule

### rtl/llp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead peak limiter datapath
// Configuration registers, delay memories, divider, gain and output stage.
// ----------------------------------------------------------------------------
module llp_datapath
   import llp_pkg::*;
#(
   parameter int LOOKAHEAD_MAX = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  frame_type             req_frame,
   input  logic                  req_eob,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output frame_type             rsp_frame,
   output logic                  rsp_eob,
   input  cmd_type               cmd,
   output status_type            status
);

   localparam int SLOT_W = (LOOKAHEAD_MAX > 1) ? $clog2(LOOKAHEAD_MAX) : 1;
   localparam int LEN_W = ($clog2(LOOKAHEAD_MAX + 1) + 1 > 11) ?
                          $clog2(LOOKAHEAD_MAX + 1) + 1 : 11;

   logic [2:0]  cfg_ch_ff;
   logic [9:0]  cfg_len_ff;
   logic [30:0] cfg_rel_ff;
   logic [30:0] cfg_lim_ff;
   logic        cfg_narrow_ff;

   logic [2:0]       ch_eff;
   logic [LEN_W-1:0] len_eff;
   logic [LEN_W-1:0] slot_p1;
   logic [SLOT_W-1:0] rd_in;

   frame_type         samp_ff;
   logic              eob_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] rd_ff;
   logic [SLOT_W-1:0] clr_ff;
   sample_type        rdata [NUM_CH];

   logic [30:0] peak_ff;
   logic [30:0] dpk_ff;
   logic [30:0] cur_mag;
   logic [30:0] rd_mag;

   logic [31:0] rem_ff;
   logic [30:0] dvd_ff;
   logic [30:0] dvs_ff;
   logic [30:0] q_ff;
   logic        neg_ff;
   logic [31:0] div_sh;
   logic        div_ge;

   logic signed [32:0] diff;
   logic [32:0]        diff_mag;
   logic signed [31:0] need;

   logic [30:0]        gain_ff, gain_in;
   logic signed [31:0] slope_ff, slope_in;
   logic signed [32:0] gain_sum;
   logic [31:0]        gain_rel;

   logic signed [31:0] mul_a;
   logic signed [63:0] prod_ff;
   logic signed [33:0] out_q;
   logic signed [33:0] lim_s;
   logic signed [33:0] out_cl;
   logic signed [31:0] out_val;

   frame_type stage_ff;
   logic      rsp_valid_ff;
   frame_type rsp_frame_ff;
   logic      rsp_eob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ch_ff     <= RST_CHANNELS;
         cfg_len_ff    <= RST_LOOKAHEAD;
         cfg_rel_ff    <= RST_RELEASE;
         cfg_lim_ff    <= RST_LIMIT;
         cfg_narrow_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHANNELS:  cfg_ch_ff     <= csr_wr_data[2:0];
            CSR_LOOKAHEAD: cfg_len_ff    <= csr_wr_data[9:0];
            CSR_RELEASE:   cfg_rel_ff    <= csr_wr_data;
            CSR_LIMIT:     cfg_lim_ff    <= csr_wr_data;
            CSR_NARROW:    cfg_narrow_ff <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (cfg_ch_ff == 3'd0) begin
         ch_eff = 3'd1;
      end else if (cfg_ch_ff > 3'(NUM_CH)) begin
         ch_eff = 3'(NUM_CH);
      end else begin
         ch_eff = cfg_ch_ff;
      end
      if (cfg_len_ff == 10'd0) begin
         len_eff = LEN_W'(1);
      end else if (LEN_W'(cfg_len_ff) > LEN_W'(LOOKAHEAD_MAX)) begin
         len_eff = LEN_W'(LOOKAHEAD_MAX);
      end else begin
         len_eff = LEN_W'(cfg_len_ff);
      end
      slot_p1 = LEN_W'(slot_ff) + LEN_W'(1);
      rd_in = (slot_p1 >= len_eff) ? '0 : slot_p1[SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int c = 0; c < NUM_CH; c++) begin
            samp_ff[c] <= cfg_narrow_ff ? {req_frame[c][15:0], 16'h0000} : req_frame[c];
         end
         eob_ff <= req_eob;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         clr_ff  <= '0;
      end else begin
         if (cmd.mem_write) begin
            slot_ff <= rd_ff;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
      sample_type mem [LOOKAHEAD_MAX];
      sample_type rdata_ff;

      always_ff @(posedge clock) begin
         if (cmd.clear_step) begin
            mem[clr_ff] <= '0;
         end else if (cmd.mem_write && (3'(g) < ch_eff)) begin
            mem[slot_ff] <= samp_ff[g];
         end
         if (cmd.mem_read) begin
            rdata_ff <= mem[rd_ff];
         end
      end

      assign rdata[g] = rdata_ff;
   end

   assign cur_mag = mag(samp_ff[cmd.chan]);
   assign rd_mag  = mag(rdata[cmd.chan]);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         peak_ff <= '0;
      end else if (cmd.peak_step && (cur_mag > peak_ff)) begin
         peak_ff <= cur_mag;
      end
      if (cmd.gain_update) begin
         dpk_ff <= '0;
      end else if (cmd.dpk_step && (rd_mag > dpk_ff)) begin
         dpk_ff <= rd_mag;
      end
   end

   // Restoring division, one quotient bit per cycle.
   assign div_sh = {rem_ff[30:0], dvd_ff[30]};
   assign div_ge = (div_sh >= {1'b0, dvs_ff});
   assign diff = $signed({2'b00, q_ff}) - $signed({2'b00, gain_ff});
   assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
   assign need = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_start_t) begin
         rem_ff <= {2'b00, cfg_lim_ff[30:1]};
         dvd_ff <= {cfg_lim_ff[0], 30'h0};
         dvs_ff <= peak_ff;
         q_ff   <= '0;
      end else if (cmd.div_start_n) begin
         rem_ff <= '0;
         dvd_ff <= diff_mag[30:0];
         dvs_ff <= 31'(len_eff);
         q_ff   <= '0;
         neg_ff <= diff[32];
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? div_sh - {1'b0, dvs_ff} : div_sh;
         dvd_ff <= {dvd_ff[29:0], 1'b0};
         q_ff   <= {q_ff[29:0], div_ge};
      end
   end

   assign gain_sum = $signed({2'b00, gain_ff}) + 33'(slope_ff);
   assign gain_rel = {1'b0, gain_ff} + {1'b0, cfg_rel_ff};

   always_comb begin
      gain_in  = gain_ff;
      slope_in = slope_ff;
      if (cmd.need_update && (need < slope_ff)) begin
         slope_in = need;
      end
      if (cmd.gain_update) begin
         if (gain_sum < $signed({2'b00, GAIN_FLOOR})) begin
            gain_in = GAIN_FLOOR;
         end else begin
            gain_in = gain_sum[30:0];
         end
      end
      if (cmd.release_step) begin
         slope_in = '0;
         if (gain_ff < UNITY_Q30) begin
            gain_in = (gain_rel > {1'b0, UNITY_Q30}) ? UNITY_Q30 : gain_rel[30:0];
         end
      end
      if (cmd.chk_apply && (prod_ff[63:30] <= {3'b000, cfg_lim_ff})) begin
         slope_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= UNITY_Q30;
         slope_ff <= '0;
      end else begin
         gain_ff  <= gain_in;
         slope_ff <= slope_in;
      end
   end

   assign mul_a = cmd.chk_mul ? $signed({1'b0, dpk_ff}) : rdata[cmd.chan];

   always_ff @(posedge clock) begin
      if (cmd.chk_mul || cmd.out_mul) begin
         prod_ff <= 64'(mul_a) * 64'($signed({1'b0, gain_ff}));
      end
   end

   assign out_q = $signed(prod_ff[63:30]);
   assign lim_s = $signed({3'b000, cfg_lim_ff});

   always_comb begin
      if (out_q > lim_s) begin
         out_cl = lim_s;
      end else if (out_q < -lim_s) begin
         out_cl = -lim_s;
      end else begin
         out_cl = out_q;
      end
      if (3'(cmd.chan) >= ch_eff) begin
         out_val = '0;
      end else if (cfg_narrow_ff) begin
         out_val = $signed(out_cl[31:0]) >>> 16;
      end else begin
         out_val = out_cl[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_store) begin
         stage_ff[cmd.chan] <= out_val;
      end
      if (cmd.emit) begin
         rsp_frame_ff <= stage_ff;
         rsp_eob_ff   <= eob_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame = rsp_frame_ff;
   assign rsp_eob   = rsp_eob_ff;

   assign status.clear_last = (clr_ff == SLOT_W'(LOOKAHEAD_MAX - 1));
   assign status.over_limit = (peak_ff > cfg_lim_ff);
   assign status.slope_neg  = slope_ff[31];
   assign status.chan_last  = (3'(cmd.chan) == (ch_eff - 3'd1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

### rtl/llp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead peak limiter checker
// Port-level assertions on the handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module llp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_a
);

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("Input ready right after an accepted item.");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("Result appeared one cycle after an accepted item.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_a)))
      else $error("Stalled result changed.");

endmodule

bind lookahead_peak_limiter llp_checker u_llp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_out_a (rsp_chan.out_a)
);
